### hw/rtl/itw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itw_pkg
// Shared field widths, command codes and the controller state type of the
// idle timeout timing wheel.
// ----------------------------------------------------------------------------
package itw_pkg;

   localparam int CMD_W  = 2;
   localparam int ID_W   = 6;
   localparam int TIME_W = 32;
   localparam int WS_W   = 7;

   typedef logic [CMD_W-1:0]  cmd_type;
   typedef logic [ID_W-1:0]   conn_id_type;
   typedef logic [TIME_W-1:0] time_type;
   typedef logic [WS_W-1:0]   wheel_size_type;

   localparam cmd_type CMD_ACTIVITY   = 2'd0;
   localparam cmd_type CMD_TICK       = 2'd1;
   localparam cmd_type CMD_DISCONNECT = 2'd2;

   localparam wheel_size_type WHEEL_SIZE_RESET = 7'd8;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACT,
      ST_LOAD,
      ST_SCAN,
      ST_CHECK,
      ST_FINISH
   } itw_state_type;

endpackage
`default_nettype wire

### hw/rtl/itw_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itw_req_if
// Request channel: one beat carries a command, a connection id and the time.
// ----------------------------------------------------------------------------
interface itw_req_if;
   import itw_pkg::*;

   logic        valid;
   logic        ready;
   cmd_type     cmd;
   conn_id_type conn_id;
   time_type    now_time;

   modport source (output valid, output cmd, output conn_id, output now_time, input ready);
   modport sink   (input valid, input cmd, input conn_id, input now_time, output ready);

endinterface
`default_nettype wire

### hw/rtl/itw_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itw_rsp_if
// Response channel: one beat reports one closed connection or an empty tick.
// ----------------------------------------------------------------------------
interface itw_rsp_if;
   import itw_pkg::*;

   logic        valid;
   logic        ready;
   logic        close_valid;
   conn_id_type close_id;
   logic        last;

   modport source (output valid, output close_valid, output close_id, output last, input ready);
   modport sink   (input valid, input close_valid, input close_id, input last, output ready);

endinterface
`default_nettype wire

### hw/rtl/idle_timeout_timing_wheel.sv
`default_nettype none
// ----------------------------------------------------------------------------
// idle_timeout_timing_wheel
// Timing wheel that closes connections idle for wheel_size ticks. Slot
// bitmaps and last activity times live in two synchronous memories.
//
//   Channel  Direction  Beat contents
//   req      in         cmd, conn_id, now_time
//   rsp      out        close_valid, close_id, last
//   csr      in         wheel_size write (csr_wr_en, csr_wr_data)
//
// An activity beat reads its slot, then writes the slot back (ST_ACT).
// A disconnect beat is handled in ST_IDLE alone. A tick loads the slot, then
// for every live member of the scanned slot runs one scan step that picks the
// member and reads its last activity, then one check step. After reset
// every slot is swept to zero with req.ready low. A stalled rsp beat holds
// the tick whenever a further beat must be sent, the final one included.
// ----------------------------------------------------------------------------
module idle_timeout_timing_wheel #(
   parameter int MAX_SLOTS = 64,
   parameter int MAX_CONNS = 64
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   itw_req_if.sink                       req,
   itw_rsp_if.source                     rsp,
   input  wire logic                     csr_wr_en,
   input  wire itw_pkg::wheel_size_type  csr_wr_data
);
   import itw_pkg::*;

   localparam int CurW  = $clog2(MAX_SLOTS);
   localparam int SizeW = $clog2(MAX_SLOTS + 1);
   localparam int CmpW  = (SizeW > WS_W) ? SizeW : WS_W;
   localparam int ConnW = $clog2(MAX_CONNS);

   itw_state_type         state_ff, state_in;
   wheel_size_type        ws_ff, ws_in;
   logic [CurW-1:0]       cursor_ff, cursor_in;
   logic [MAX_CONNS-1:0]  live_ff, live_in;
   logic [CurW-1:0]       addr_ff, addr_in;
   logic [ConnW-1:0]      id_ff, id_in;
   time_type              now_ff, now_in;
   logic [MAX_CONNS-1:0]  mask_ff, mask_in;
   logic [ConnW-1:0]      cand_ff, cand_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [ConnW-1:0]      pend_id_ff, pend_id_in;
   logic [CurW-1:0]       clr_ff, clr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_close_valid_ff, rsp_close_valid_in;
   conn_id_type           rsp_close_id_ff, rsp_close_id_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [MAX_CONNS-1:0]  slot_mem [MAX_SLOTS];
   logic [MAX_CONNS-1:0]  slot_rd_ff;
   time_type              la_mem [MAX_CONNS];
   time_type              la_rd_ff;

   logic                  slot_wr_en;
   logic [CurW-1:0]       slot_wr_addr;
   logic [MAX_CONNS-1:0]  slot_wr_data;
   logic [CurW-1:0]       slot_rd_addr;
   logic                  la_wr_en;

   logic [CmpW-1:0]       ws_ext;
   logic [SizeW-1:0]      size;
   logic [CurW-1:0]       cur;
   logic [CurW-1:0]       pos;
   logic [SizeW-1:0]      cur_p1;
   logic [CurW-1:0]       next_cur;
   logic                  accept;
   logic                  in_range;
   logic                  out_free;
   logic                  due;
   logic                  first_found;
   logic [ConnW-1:0]      first_idx;
   logic                  clr_done;
   logic                  check_close;

   always_comb begin
      ws_ext = CmpW'(ws_ff);
      if (ws_ff == '0) begin
         size = SizeW'(1);
      end else if (ws_ext > CmpW'(MAX_SLOTS)) begin
         size = SizeW'(MAX_SLOTS);
      end else begin
         size = SizeW'(ws_ext);
      end
      cur      = (SizeW'(cursor_ff) >= size) ? '0 : cursor_ff;
      pos      = (cur == '0) ? CurW'(size - SizeW'(1)) : cur - CurW'(1);
      cur_p1   = SizeW'(addr_ff) + SizeW'(1);
      next_cur = (cur_p1 >= size) ? '0 : CurW'(cur_p1);
   end

   assign accept    = req.valid && req.ready;
   assign in_range  = {1'b0, req.conn_id} < (ID_W + 1)'(MAX_CONNS);
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign due       = ({1'b0, la_rd_ff} + (TIME_W + 1)'(size) - (TIME_W + 1)'(1))
                      <= {1'b0, now_ff};
   assign clr_done  = (clr_ff == CurW'(MAX_SLOTS - 1));
   assign check_close = due && !(pend_valid_ff && !out_free);

   itw_first_set #(
      .WIDTH (MAX_CONNS)
   ) u_first_set (
      .mask  (mask_ff),
      .found (first_found),
      .index (first_idx)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (req.cmd == CMD_ACTIVITY && in_range) begin
                  state_in = ST_ACT;
               end else if (req.cmd == CMD_TICK) begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_ACT:   state_in = ST_IDLE;
         ST_LOAD:  state_in = ST_SCAN;
         ST_SCAN:  state_in = first_found ? ST_CHECK : ST_FINISH;
         ST_CHECK: begin
            if (!due || check_close) state_in = ST_SCAN;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      req.ready          = (state_ff == ST_IDLE);
      ws_in              = csr_wr_en ? csr_wr_data : ws_ff;
      cursor_in          = cursor_ff;
      live_in            = live_ff;
      addr_in            = addr_ff;
      id_in              = id_ff;
      now_in             = now_ff;
      mask_in            = mask_ff;
      cand_in            = cand_ff;
      pend_valid_in      = pend_valid_ff;
      pend_id_in         = pend_id_ff;
      clr_in             = clr_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp.ready;
      rsp_close_valid_in = rsp_close_valid_ff;
      rsp_close_id_in    = rsp_close_id_ff;
      rsp_last_in        = rsp_last_ff;
      slot_rd_addr       = (req.cmd == CMD_TICK) ? cur : pos;
      slot_wr_en         = 1'b0;
      slot_wr_addr       = addr_ff;
      slot_wr_data       = '0;
      la_wr_en           = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            slot_wr_en   = 1'b1;
            slot_wr_addr = clr_ff;
            clr_in       = clr_ff + CurW'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               addr_in = slot_rd_addr;
               id_in   = req.conn_id[ConnW-1:0];
               now_in  = req.now_time;
               if (in_range && req.cmd == CMD_ACTIVITY) begin
                  live_in[req.conn_id[ConnW-1:0]] = 1'b1;
                  la_wr_en = 1'b1;
               end else if (in_range && req.cmd == CMD_DISCONNECT) begin
                  live_in[req.conn_id[ConnW-1:0]] = 1'b0;
               end
            end
         end
         ST_ACT: begin
            slot_wr_en   = 1'b1;
            slot_wr_data = slot_rd_ff | (MAX_CONNS'(1) << id_ff);
         end
         ST_LOAD: begin
            mask_in       = slot_rd_ff & live_ff;
            pend_valid_in = 1'b0;
         end
         ST_SCAN: begin
            if (first_found) begin
               cand_in             = first_idx;
               mask_in[first_idx] = 1'b0;
            end
         end
         ST_CHECK: begin
            if (check_close) begin
               live_in[cand_ff] = 1'b0;
               pend_valid_in    = 1'b1;
               pend_id_in       = cand_ff;
               if (pend_valid_ff) begin
                  rsp_valid_in       = 1'b1;
                  rsp_close_valid_in = 1'b1;
                  rsp_close_id_in    = ID_W'(pend_id_ff);
                  rsp_last_in        = 1'b0;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_close_valid_in = pend_valid_ff;
               rsp_close_id_in    = pend_valid_ff ? ID_W'(pend_id_ff) : '0;
               rsp_last_in        = 1'b1;
               pend_valid_in      = 1'b0;
               slot_wr_en         = 1'b1;
               cursor_in          = next_cur;
            end
         end
         default: begin
            slot_wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (slot_wr_en) begin
         slot_mem[slot_wr_addr] <= slot_wr_data;
      end
      slot_rd_ff <= slot_mem[slot_rd_addr];
      if (la_wr_en) begin
         la_mem[req.conn_id[ConnW-1:0]] <= req.now_time;
      end
      if (state_ff == ST_SCAN) begin
         la_rd_ff <= la_mem[first_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         ws_ff         <= WHEEL_SIZE_RESET;
         cursor_ff     <= '0;
         live_ff       <= '0;
         pend_valid_ff <= 1'b0;
         clr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ws_ff         <= ws_in;
         cursor_ff     <= cursor_in;
         live_ff       <= live_in;
         pend_valid_ff <= pend_valid_in;
         clr_ff        <= clr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff            <= addr_in;
      id_ff              <= id_in;
      now_ff             <= now_in;
      mask_ff            <= mask_in;
      cand_ff            <= cand_in;
      pend_id_ff         <= pend_id_in;
      rsp_close_valid_ff <= rsp_close_valid_in;
      rsp_close_id_ff    <= rsp_close_id_in;
      rsp_last_ff        <= rsp_last_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.close_valid = rsp_close_valid_ff;
   assign rsp.close_id    = rsp_close_id_ff;
   assign rsp.last        = rsp_last_ff;

   // An empty beat is always the only beat of its tick.
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_close_valid_ff |-> rsp_last_ff)
      else $error("empty response beat without last");

   // A held close must never be stranded once the scan returns to idle.
   a_no_stranded_close: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !pend_valid_ff)
      else $error("pending close left behind");

   // The candidate under check has already been removed from the scan mask.
   a_cand_removed: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CHECK |-> !mask_ff[cand_ff])
      else $error("candidate still in scan mask");

   // A connection that is closed loses its live bit.
   a_close_kills_live: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CHECK && check_close |=> !live_ff[$past(cand_ff)])
      else $error("closed connection still live");

endmodule
`default_nettype wire

### hw/rtl/itw_first_set.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itw_first_set
// Finds the lowest set bit of a member mask and reports its index.
// ----------------------------------------------------------------------------
module itw_first_set #(
   parameter int WIDTH = 64
) (
   input  wire logic [WIDTH-1:0]         mask,
   output logic                          found,
   output logic [$clog2(WIDTH)-1:0]      index
);

   always_comb begin
      found = 1'b0;
      index = '0;
      for (int i = WIDTH - 1; i >= 0; i--) begin
         if (mask[i]) begin
            found = 1'b1;
            index = ($clog2(WIDTH))'(i);
         end
      end
   end

endmodule
`default_nettype wire
